[src/bmx_pkg.sv]
package bmx_pkg;

  // Default sizes
  localparam int KEY_BITS_DEF   = 31;
  localparam int POOL_NODES_DEF = 32768;
  localparam int COUNT_BITS_DEF = 16;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;      // latch key, start walk at the root
    logic    clear;     // drop all nodes
    logic    restart;   // walk again from the root
    logic    rd_same;   // read node on the key-bit branch
    logic    rd_opp;    // read node on the opposite branch
    logic    descend;   // move to the node just read
    logic    set_acc;   // set the result bit of this level
    logic    wr_inc;    // write back node read with count + 1
    logic    wr_dec;    // write back node read with count - 1
    logic    link_new;  // point current node at the next free node
    logic    alloc;     // write a fresh node and take the next free index
    logic    set_st;    // record status
    status_t st;
    logic    emit;      // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic same_zero;  // no child on the key-bit branch
    logic opp_zero;   // no child on the opposite branch
    logic cnt_max;    // node read holds the largest count
    logic cnt_zero;   // node read holds a zero count
    logic lvl_last;   // at the least significant bit
    logic lvl_top;    // at the most significant bit
    logic pool_over;  // allocating the rest of the path overflows the pool
  } stat_t;

endpackage

[src/bmx_if.sv]
// Request channel: operation and key
interface bmx_req_if #(
  parameter int KEY_BITS = bmx_pkg::KEY_BITS_DEF
);
  import bmx_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 op;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

// Result channel: largest XOR and status
interface bmx_rsp_if #(
  parameter int KEY_BITS = bmx_pkg::KEY_BITS_DEF
);
  import bmx_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] xor_max;
  status_t             status;

  modport source (output valid, output xor_max, output status, input ready);
  modport sink   (input valid, input xor_max, input status, output ready);
endinterface

[src/bmx_dp.sv]
module bmx_dp #(
  parameter int KEY_BITS   = bmx_pkg::KEY_BITS_DEF,
  parameter int POOL_NODES = bmx_pkg::POOL_NODES_DEF,
  parameter int COUNT_BITS = bmx_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmx_pkg::cmd_t       cmd,
  output bmx_pkg::stat_t      stat,
  input  logic [KEY_BITS-1:0] in_key,
  output logic [KEY_BITS-1:0] out_xor_max,
  output bmx_pkg::status_t    out_status
);
  import bmx_pkg::*;

  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int NU_W   = $clog2(POOL_NODES + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int SUM_W  = ((NU_W > LVL_W) ? NU_W : LVL_W) + 2;

  typedef struct packed {
    logic [NODE_W-1:0]     c0;
    logic [NODE_W-1:0]     c1;
    logic [COUNT_BITS-1:0] cnt;
  } node_t;

  // Node pool; root links live in registers
  node_t mem [POOL_NODES];
  node_t rd_node_r;

  logic [KEY_BITS-1:0]   key_r;
  logic [LVL_W-1:0]      lvl_r;
  logic [NODE_W-1:0]     u_r;
  logic [NODE_W-1:0]     v_r;
  logic [NODE_W-1:0]     cur_c0_r;
  logic [NODE_W-1:0]     cur_c1_r;
  logic [COUNT_BITS-1:0] cur_cnt_r;
  logic [NU_W-1:0]       nodes_used_r;
  logic [NODE_W-1:0]     root0_r;
  logic [NODE_W-1:0]     root1_r;
  logic [KEY_BITS-1:0]   acc_r;
  status_t               st_r;
  logic [KEY_BITS-1:0]   out_xor_r;
  status_t               out_st_r;

  logic                  b_cur;
  logic                  b_next;
  logic [NODE_W-1:0]     link_same;
  logic [NODE_W-1:0]     link_opp;
  logic [NODE_W-1:0]     nu_idx;
  logic [SUM_W-1:0]      need_sum;
  logic                  mem_we;
  logic [NODE_W-1:0]     mem_wa;
  node_t                 mem_wd;
  logic                  mem_re;
  logic [NODE_W-1:0]     mem_ra;
  logic [COUNT_BITS-1:0] cnt_inc;

  // Branch selection for the current level
  assign b_cur     = key_r[lvl_r];
  assign b_next    = key_r[lvl_r - LVL_W'(1)];
  assign link_same = b_cur ? cur_c1_r : cur_c0_r;
  assign link_opp  = b_cur ? cur_c0_r : cur_c1_r;
  assign nu_idx    = nodes_used_r[NODE_W-1:0];
  assign cnt_inc   = rd_node_r.cnt + COUNT_BITS'(1);

  // Nodes in use plus nodes missing from this level down
  assign need_sum = SUM_W'(nodes_used_r) + SUM_W'(lvl_r) + SUM_W'(1);

  // Status flags
  assign stat.same_zero = (link_same == '0);
  assign stat.opp_zero  = (link_opp == '0);
  assign stat.cnt_max   = (rd_node_r.cnt == {COUNT_BITS{1'b1}});
  assign stat.cnt_zero  = (rd_node_r.cnt == '0);
  assign stat.lvl_last  = (lvl_r == '0);
  assign stat.lvl_top   = (lvl_r == LVL_W'(KEY_BITS - 1));
  assign stat.pool_over = (need_sum > SUM_W'(POOL_NODES));

  // Single write port: count update, relink or fresh node
  always_comb begin
    mem_we = 1'b0;
    mem_wa = v_r;
    mem_wd = rd_node_r;
    if (cmd.wr_inc) begin
      mem_we     = 1'b1;
      mem_wd.cnt = cnt_inc;
    end else if (cmd.wr_dec) begin
      mem_we     = 1'b1;
      mem_wd.cnt = rd_node_r.cnt - COUNT_BITS'(1);
    end else if (cmd.link_new && (u_r != '0)) begin
      mem_we     = 1'b1;
      mem_wa     = u_r;
      mem_wd.c0  = b_cur ? cur_c0_r : nu_idx;
      mem_wd.c1  = b_cur ? nu_idx : cur_c1_r;
      mem_wd.cnt = cur_cnt_r;
    end else if (cmd.alloc) begin
      mem_we     = 1'b1;
      mem_wa     = nu_idx;
      mem_wd.c0  = '0;
      mem_wd.c1  = '0;
      mem_wd.cnt = COUNT_BITS'(1);
      if (!stat.lvl_last) begin
        if (b_next) mem_wd.c1 = nu_idx + NODE_W'(1);
        else        mem_wd.c0 = nu_idx + NODE_W'(1);
      end
    end
  end

  assign mem_re = cmd.rd_same || cmd.rd_opp;
  assign mem_ra = cmd.rd_opp ? link_opp : link_same;

  // Node memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_node_r <= mem[mem_ra];
  end

  // Pool bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      nodes_used_r <= NU_W'(1);
      root0_r      <= '0;
      root1_r      <= '0;
    end else begin
      if (cmd.alloc) nodes_used_r <= nodes_used_r + NU_W'(1);
      if (cmd.link_new && (u_r == '0)) begin
        if (b_cur) root1_r <= nu_idx;
        else       root0_r <= nu_idx;
      end
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (cmd.load) key_r <= in_key;
    if (cmd.load || cmd.restart) begin
      lvl_r    <= LVL_W'(KEY_BITS - 1);
      u_r      <= '0;
      cur_c0_r <= root0_r;
      cur_c1_r <= root1_r;
    end else if (cmd.descend) begin
      lvl_r     <= lvl_r - LVL_W'(1);
      u_r       <= v_r;
      cur_c0_r  <= rd_node_r.c0;
      cur_c1_r  <= rd_node_r.c1;
      cur_cnt_r <= cmd.wr_inc ? cnt_inc : rd_node_r.cnt;
    end else if (cmd.alloc) begin
      lvl_r <= lvl_r - LVL_W'(1);
    end
    if (mem_re) v_r <= mem_ra;
  end

  // Result accumulation and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
      st_r  <= ST_OK;
    end else begin
      if (cmd.set_acc) acc_r[lvl_r] <= 1'b1;
      if (cmd.set_st)  st_r <= cmd.st;
    end
    if (cmd.emit) begin
      out_xor_r <= acc_r;
      out_st_r  <= st_r;
    end
  end

  assign out_xor_max = out_xor_r;
  assign out_status  = out_st_r;

endmodule

[src/bmx_ctrl.sv]
module bmx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmx_pkg::op_t    in_op,
  output logic            out_valid,
  input  logic            out_ready,
  output bmx_pkg::cmd_t   cmd,
  input  bmx_pkg::stat_t  stat
);
  import bmx_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_I1_LINK  = 14'b00000000000010,
    S_I1_DATA  = 14'b00000000000100,
    S_I2_LINK  = 14'b00000000001000,
    S_I2_DATA  = 14'b00000000010000,
    S_I2_ALLOC = 14'b00000000100000,
    S_D1_LINK  = 14'b00000001000000,
    S_D1_DATA  = 14'b00000010000000,
    S_D2_LINK  = 14'b00000100000000,
    S_D2_DATA  = 14'b00001000000000,
    S_Q_OPP    = 14'b00010000000000,
    S_Q_ODATA  = 14'b00100000000000,
    S_Q_SDATA  = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing of the trie walks
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st    = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            OP_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_FIN;
            end
            OP_INSERT: state_nxt = S_I1_LINK;
            OP_DELETE: state_nxt = S_D1_LINK;
            OP_QUERY:  state_nxt = S_Q_OPP;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      // insert, first pass: find the missing part and check counts
      S_I1_LINK: begin
        if (stat.same_zero) begin
          if (stat.pool_over) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            cmd.restart = 1'b1;
            state_nxt   = S_I2_LINK;
          end
        end else begin
          cmd.rd_same = 1'b1;
          state_nxt   = S_I1_DATA;
        end
      end
      S_I1_DATA: begin
        if (stat.cnt_max) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
          state_nxt  = S_FIN;
        end else if (stat.lvl_last) begin
          cmd.restart = 1'b1;
          state_nxt   = S_I2_LINK;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = S_I1_LINK;
        end
      end
      // insert, second pass: raise counts, then build the new tail
      S_I2_LINK: begin
        if (stat.same_zero) begin
          cmd.link_new = 1'b1;
          state_nxt    = S_I2_ALLOC;
        end else begin
          cmd.rd_same = 1'b1;
          state_nxt   = S_I2_DATA;
        end
      end
      S_I2_DATA: begin
        cmd.wr_inc  = 1'b1;
        cmd.descend = 1'b1;
        state_nxt   = stat.lvl_last ? S_FIN : S_I2_LINK;
      end
      S_I2_ALLOC: begin
        cmd.alloc = 1'b1;
        if (stat.lvl_last) state_nxt = S_FIN;
      end
      // delete, first pass: the full path must exist with a live leaf
      S_D1_LINK: begin
        if (stat.same_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_same = 1'b1;
          state_nxt   = S_D1_DATA;
        end
      end
      S_D1_DATA: begin
        if (stat.lvl_last) begin
          if (stat.cnt_zero) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_NOT_FOUND;
            state_nxt  = S_FIN;
          end else begin
            cmd.restart = 1'b1;
            state_nxt   = S_D2_LINK;
          end
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = S_D1_LINK;
        end
      end
      // delete, second pass: lower counts
      S_D2_LINK: begin
        cmd.rd_same = 1'b1;
        state_nxt   = S_D2_DATA;
      end
      S_D2_DATA: begin
        cmd.wr_dec  = 1'b1;
        cmd.descend = 1'b1;
        state_nxt   = stat.lvl_last ? S_FIN : S_D2_LINK;
      end
      // query: try the opposite branch, fall back to the same one
      S_Q_OPP: begin
        if (!stat.opp_zero) begin
          cmd.rd_opp = 1'b1;
          state_nxt  = S_Q_ODATA;
        end else if (stat.same_zero) begin
          cmd.set_st = stat.lvl_top;
          cmd.st     = ST_EMPTY;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_same = 1'b1;
          state_nxt   = S_Q_SDATA;
        end
      end
      S_Q_ODATA: begin
        if (!stat.cnt_zero) begin
          cmd.descend = 1'b1;
          cmd.set_acc = 1'b1;
          state_nxt   = stat.lvl_last ? S_FIN : S_Q_OPP;
        end else if (stat.same_zero) begin
          cmd.set_st = stat.lvl_top;
          cmd.st     = ST_EMPTY;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_same = 1'b1;
          state_nxt   = S_Q_SDATA;
        end
      end
      S_Q_SDATA: begin
        if (stat.lvl_top && stat.cnt_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
          state_nxt  = S_FIN;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = stat.lvl_last ? S_FIN : S_Q_OPP;
        end
      end
      // hand the result over once the output register is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/binary_trie_max_xor.sv]
// Binary trie over a multiset of keys, answering max-XOR queries.
// in_req carries op (clear, insert, delete, query) and key; out_rsp returns
// xor_max and status, one result per request, in request order.
// Both channels use valid/ready; a request is taken at an edge where both
// are high. One request is worked at a time; the next can be taken in the cycle
// after the previous result enters the output register, even if not yet taken.
// Steps per request: a clear empties the set and goes straight to the
//   result. An insert walks the existing path checking counts and room in
//   the pool, then walks it again raising counts, then links and writes
//   one new node per missing level. A delete checks the full path and a
//   live leaf, then walks it again lowering counts. A query tries the
//   opposite branch at each level and falls back to the same one.
// The walk is bound by the single node memory: one registered read for each
// node visited, and one write port for count updates, relinks and new nodes.
// Reset (synchronous, rst_n low) empties the set: root links cleared and
// the pool reduced to the root. No memory clearing pass is needed.
// When out_rsp.ready is low the result holds; a finished request then waits
// in its last state until the output register frees up.
module binary_trie_max_xor #(
  parameter int KEY_BITS   = bmx_pkg::KEY_BITS_DEF,
  parameter int POOL_NODES = bmx_pkg::POOL_NODES_DEF,
  parameter int COUNT_BITS = bmx_pkg::COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  bmx_req_if.sink  in_req,
  bmx_rsp_if.source out_rsp
);
  import bmx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bmx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_op     (in_req.op),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bmx_dp #(
    .KEY_BITS   (KEY_BITS),
    .POOL_NODES (POOL_NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_key      (in_req.key),
    .out_xor_max (out_rsp.xor_max),
    .out_status  (out_rsp.status)
  );

`ifndef SYNTHESIS
  // one memory write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_inc, cmd.wr_dec, cmd.link_new, cmd.alloc}))
    else $error("more than one node write in a cycle");

  // one memory read per cycle
  a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_same, cmd.rd_opp}))
    else $error("more than one node read in a cycle");

  // descending uses data read in the previous cycle
  a_descend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.descend |-> $past(cmd.rd_same || cmd.rd_opp))
    else $error("descend without a preceding node read");

  // a finished result shows up on the output
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_rsp.valid)
    else $error("result loaded but not presented");
`endif

endmodule
